// ===== hw/rtl/tpb_pkg.sv =====
// types, register indexes, reset values and saturation helpers for transformed_point_bounds
package tpb_pkg;

  typedef logic signed [31:0] coord_t;
  typedef logic signed [15:0] coef_t;
  typedef logic signed [47:0] prod_t;
  typedef logic [47:0]        row_t;
  typedef logic [30:0]        pad_t;
  typedef logic [2:0]         cfg_idx_t;

  localparam int NUM_AXES  = 3;
  localparam int COEF_FRAC = 14;

  localparam cfg_idx_t REG_ROW_X   = 3'd0;
  localparam cfg_idx_t REG_ROW_Y   = 3'd1;
  localparam cfg_idx_t REG_ROW_Z   = 3'd2;
  localparam cfg_idx_t REG_SHIFT_X = 3'd3;
  localparam cfg_idx_t REG_SHIFT_Y = 3'd4;
  localparam cfg_idx_t REG_SHIFT_Z = 3'd5;
  localparam cfg_idx_t REG_PAD     = 3'd6;

  localparam row_t ROW_X_RESET = 48'h4000_0000_0000;
  localparam row_t ROW_Y_RESET = 48'h0000_4000_0000;
  localparam row_t ROW_Z_RESET = 48'h0000_0000_4000;

  localparam coord_t COORD_MAX = 32'sh7fff_ffff;
  localparam coord_t COORD_MIN = 32'sh8000_0000;

  // clamp the transformed sum to 32 bits
  function automatic coord_t sat37(input logic signed [36:0] v);
    coord_t r;
    if (v[36:31] == 6'b000000 || v[36:31] == 6'b111111) begin
      r = v[31:0];
    end else begin
      r = v[36] ? COORD_MIN : COORD_MAX;
    end
    return r;
  endfunction

  // clamp a padded corner to 32 bits
  function automatic coord_t sat33(input logic signed [32:0] v);
    coord_t r;
    if (v[32] == v[31]) begin
      r = v[31:0];
    end else begin
      r = v[32] ? COORD_MIN : COORD_MAX;
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/transformed_point_bounds.sv =====
// transformed_point_bounds: affine transform of point runs and padded per-axis bounding box
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  s_tdata = point_x, point_y, point_z; s_tlast = last_point
//   m_*       out  m_tvalid/m_tready  m_tdata = lower_x/y/z, upper_x/y/z
//   cfg_*     in   cfg_valid/cfg_ready cfg_index, cfg_data (48 bits; low bits but for rows)
//
// one point per cycle but for the stall below; a run's box reaches m_* via box and output regs
// pipeline: input reg, coefficient multipliers, sum/shift/translate, min/max update, padding
// rst is synchronous; it restores the identity transform, zero shift and pad, and an empty box
// a stalled output holds back a point that ends a run once two boxes wait, and the input behind it
module transformed_point_bounds (
  input  logic          clk,
  input  logic          rst,
  input  logic          s_tvalid,
  output logic          s_tready,
  input  logic [95:0]   s_tdata,   // point_x, point_y, point_z
  input  logic          s_tlast,
  output logic          m_tvalid,
  input  logic          m_tready,
  output logic [191:0]  m_tdata,   // lower_x, lower_y, lower_z, upper_x, upper_y, upper_z
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  tpb_pkg::cfg_idx_t cfg_index,
  input  logic [47:0]   cfg_data
);

  localparam int NA = tpb_pkg::NUM_AXES;

  // configuration
  tpb_pkg::row_t   rows   [NA];
  tpb_pkg::coord_t shifts [NA];
  tpb_pkg::pad_t   pad_width;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      rows[0]   <= tpb_pkg::ROW_X_RESET;
      rows[1]   <= tpb_pkg::ROW_Y_RESET;
      rows[2]   <= tpb_pkg::ROW_Z_RESET;
      shifts[0] <= '0;
      shifts[1] <= '0;
      shifts[2] <= '0;
      pad_width <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        tpb_pkg::REG_ROW_X:   rows[0]   <= cfg_data;
        tpb_pkg::REG_ROW_Y:   rows[1]   <= cfg_data;
        tpb_pkg::REG_ROW_Z:   rows[2]   <= cfg_data;
        tpb_pkg::REG_SHIFT_X: shifts[0] <= cfg_data[31:0];
        tpb_pkg::REG_SHIFT_Y: shifts[1] <= cfg_data[31:0];
        tpb_pkg::REG_SHIFT_Z: shifts[2] <= cfg_data[31:0];
        tpb_pkg::REG_PAD:     pad_width <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  // pipeline control
  logic v1, v2, v3, box_valid;
  logic last1, last2, last3;
  logic rdy_out, box_free, take3, rdy3, rdy2, rdy1;

  assign rdy_out  = !m_tvalid || m_tready;
  assign box_free = !box_valid || rdy_out;
  assign take3    = v3 && (!last3 || box_free);
  assign rdy3     = !v3 || take3;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign s_tready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= s_tvalid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1: input register
  tpb_pkg::coord_t pt [NA];

  always_ff @(posedge clk) begin
    if (rdy1 && s_tvalid) begin
      pt[0] <= s_tdata[31:0];
      pt[1] <= s_tdata[63:32];
      pt[2] <= s_tdata[95:64];
      last1 <= s_tlast;
    end
  end

  // stage 2: one 16x32 product per coefficient
  tpb_pkg::prod_t prod      [NA][NA];
  tpb_pkg::prod_t prod_next [NA][NA];

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      for (int k = 0; k < NA; k++) begin
        prod_next[r][k] = tpb_pkg::prod_t'(tpb_pkg::coef_t'(rows[r][47 - 16*k -: 16]))
                        * tpb_pkg::prod_t'(pt[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy2 && v1) begin
      prod  <= prod_next;
      last2 <= last1;
    end
  end

  // stage 3: sum, arithmetic shift, translate, saturate
  tpb_pkg::coord_t tp      [NA];
  tpb_pkg::coord_t tp_next [NA];
  logic signed [49:0] acc  [NA];
  logic signed [36:0] moved [NA];

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      acc[r]     = 50'(prod[r][0]) + 50'(prod[r][1]) + 50'(prod[r][2]);
      moved[r]   = 37'($signed(acc[r][49:tpb_pkg::COEF_FRAC])) + 37'(shifts[r]);
      tp_next[r] = tpb_pkg::sat37(moved[r]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy3 && v2) begin
      tp    <= tp_next;
      last3 <= last2;
    end
  end

  // stage 4: running box, handed to the box register on the last point
  tpb_pkg::coord_t run_min [NA];
  tpb_pkg::coord_t run_max [NA];
  tpb_pkg::coord_t min_next [NA];
  tpb_pkg::coord_t max_next [NA];
  tpb_pkg::coord_t box_min [NA];
  tpb_pkg::coord_t box_max [NA];

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      min_next[r] = (tp[r] < run_min[r]) ? tp[r] : run_min[r];
      max_next[r] = (tp[r] > run_max[r]) ? tp[r] : run_max[r];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int r = 0; r < NA; r++) begin
        run_min[r] <= tpb_pkg::COORD_MAX;
        run_max[r] <= tpb_pkg::COORD_MIN;
      end
    end else if (take3) begin
      for (int r = 0; r < NA; r++) begin
        run_min[r] <= last3 ? tpb_pkg::COORD_MAX : min_next[r];
        run_max[r] <= last3 ? tpb_pkg::COORD_MIN : max_next[r];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      box_valid <= 1'b0;
    end else if (take3 && last3) begin
      box_valid <= 1'b1;
    end else if (rdy_out) begin
      box_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take3 && last3) begin
      box_min <= min_next;
      box_max <= max_next;
    end
  end

  // stage 5: padding into the output register
  tpb_pkg::coord_t lo_next [NA];
  tpb_pkg::coord_t hi_next [NA];

  always_comb begin
    for (int r = 0; r < NA; r++) begin
      lo_next[r] = tpb_pkg::sat33(33'(box_min[r]) - $signed({2'b00, pad_width}));
      hi_next[r] = tpb_pkg::sat33(33'(box_max[r]) + $signed({2'b00, pad_width}));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (rdy_out) begin
      m_tvalid <= box_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy_out && box_valid) begin
      m_tdata <= {hi_next[2], hi_next[1], hi_next[0], lo_next[2], lo_next[1], lo_next[0]};
    end
  end

endmodule

// ===== hw/rtl/tpb_checker.sv =====
// port-level checks for transformed_point_bounds, bound to the top level
module tpb_checker (
  input logic         clk,
  input logic         rst,
  input logic         s_tready,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [191:0] m_tdata
);

  tpb_pkg::coord_t lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;

  assign lo_x = m_tdata[31:0];
  assign lo_y = m_tdata[63:32];
  assign lo_z = m_tdata[95:64];
  assign hi_x = m_tdata[127:96];
  assign hi_y = m_tdata[159:128];
  assign hi_z = m_tdata[191:160];

  // a waiting box keeps its value until the transfer
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("output box changed while stalled");

  // an emitted box is never empty, padding keeps the order
  a_box_order: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> (lo_x <= hi_x) && (lo_y <= hi_y) && (lo_z <= hi_z))
    else $error("box lower corner above upper corner");

  // leaving reset the pipeline is empty and ready
  a_reset_empty: assert property (@(posedge clk)
    $past(rst) && !rst |-> s_tready && !m_tvalid)
    else $error("pipeline not empty after reset");

endmodule

bind transformed_point_bounds tpb_checker u_tpb_checker (.*);
